// ----- rtl/core/tagged_write_queue_byte_budget_assert.svh -----
// Assertion macros for the tagged write queue.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef TAGGED_WRITE_QUEUE_BYTE_BUDGET_ASSERT_SVH
`define TAGGED_WRITE_QUEUE_BYTE_BUDGET_ASSERT_SVH
`ifndef NO_ASSERTIONS
// property must hold at every edge out of reset
`define TWQ_ASSERT(lbl, clk_s, rst_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);
// antecedent implies consequent in the next cycle
`define TWQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TWQ_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define TWQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg)
`endif
`endif

// ----- rtl/core/twq_pkg.sv -----
// Shared types and constants for the tagged write queue.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package twq_pkg;
	localparam int TAG_BITS    = 64;
	localparam int BUDGET_BITS = 24;
	localparam int REQ_BITS    = 3;
	localparam logic [BUDGET_BITS-1:0] BUDGET_RESET = 24'd1048576;

	typedef enum logic [REQ_BITS-1:0] {
		REQ_ENQUEUE = 3'd0,
		REQ_DROP    = 3'd1,
		REQ_CLOSE   = 3'd2,
		REQ_TAKE    = 3'd3,
		REQ_DONE    = 3'd4
	} req_type_t;

	// chain control, broadcast to every cell
	typedef struct packed {
		logic load;   // tail cell takes the incoming descriptor
		logic shift;  // each cell with an occupied neighbour takes that neighbour's descriptor
		logic keep;   // with shift: head descriptor re-enters at the tail
	} chain_ctrl_t;
endpackage
`default_nettype wire

// ----- rtl/core/twq_if.sv -----
// Request and response channel interfaces for the tagged write queue.
// Depends on twq_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface twq_req_if #(
	parameter int LENGTH_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic [twq_pkg::REQ_BITS-1:0]  req_type;
	logic [LENGTH_BITS-1:0]        frame_length;
	logic [twq_pkg::TAG_BITS-1:0]  tag;
	logic                          write_failed;

	modport source (output valid, req_type, frame_length, tag, write_failed, input ready);
	modport sink   (input valid, req_type, frame_length, tag, write_failed, output ready);
endinterface

interface twq_rsp_if #(
	parameter int QUEUE_DEPTH = 64,
	parameter int LENGTH_BITS = 16
);
	localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int BACKLOG_BITS =
		((LENGTH_BITS > twq_pkg::BUDGET_BITS) ? LENGTH_BITS : twq_pkg::BUDGET_BITS) + 1;

	logic                          valid;
	logic                          ready;
	logic                          accepted;
	logic [COUNT_BITS-1:0]         dropped_count;
	logic                          sent_valid;
	logic [LENGTH_BITS-1:0]        sent_length;
	logic [twq_pkg::TAG_BITS-1:0]  sent_tag;
	logic [BACKLOG_BITS-1:0]       backlog_bytes;
	logic [LENGTH_BITS-1:0]        in_flight_bytes;
	logic [COUNT_BITS-1:0]         queued_count;
	logic                          failed;
	logic                          closed;

	modport source (output valid, accepted, dropped_count, sent_valid, sent_length, sent_tag,
		backlog_bytes, in_flight_bytes, queued_count, failed, closed, input ready);
	modport sink   (input valid, accepted, dropped_count, sent_valid, sent_length, sent_tag,
		backlog_bytes, in_flight_bytes, queued_count, failed, closed, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/twq_cell.sv -----
// One descriptor cell of the queue chain: a length and a tag.
// Depends on twq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module twq_cell #(
	parameter int LENGTH_BITS = 16
) (
	input  wire                          clk,
	input  wire twq_pkg::chain_ctrl_t    ctrl,
	input  wire                          occ_self,
	input  wire                          occ_prev,
	input  wire                          occ_next,
	input  wire [LENGTH_BITS-1:0]        next_len,
	input  wire [twq_pkg::TAG_BITS-1:0]  next_tag,
	input  wire [LENGTH_BITS-1:0]        head_len,
	input  wire [twq_pkg::TAG_BITS-1:0]  head_tag,
	input  wire [LENGTH_BITS-1:0]        in_len,
	input  wire [twq_pkg::TAG_BITS-1:0]  in_tag,
	output logic [LENGTH_BITS-1:0]       len_q,
	output logic [twq_pkg::TAG_BITS-1:0] tag_q
);
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			if (occ_next) begin
				len_q <= next_len;
				tag_q <= next_tag;
			end else if (occ_self && ctrl.keep) begin
				// last live cell catches the recirculated head
				len_q <= head_len;
				tag_q <= head_tag;
			end
		end else if (ctrl.load && !occ_self && occ_prev) begin
			len_q <= in_len;
			tag_q <= in_tag;
		end
	end
endmodule
`default_nettype wire

// ----- rtl/core/twq_chain.sv -----
// Row of descriptor cells; occupancy follows from the entry count.
// Depends on twq_pkg and twq_cell.
`timescale 1ns / 1ps
`default_nettype none
module twq_chain #(
	parameter int QUEUE_DEPTH = 64,
	parameter int LENGTH_BITS = 16,
	parameter int COUNT_BITS  = 7
) (
	input  wire                          clk,
	input  wire [COUNT_BITS-1:0]         count,
	input  wire twq_pkg::chain_ctrl_t    ctrl,
	input  wire [LENGTH_BITS-1:0]        in_len,
	input  wire [twq_pkg::TAG_BITS-1:0]  in_tag,
	output logic [LENGTH_BITS-1:0]       head_len,
	output logic [twq_pkg::TAG_BITS-1:0] head_tag
);
	logic [QUEUE_DEPTH:0]         occ;
	logic [QUEUE_DEPTH-1:0]       occ_prev;
	logic [LENGTH_BITS-1:0]       len_a [QUEUE_DEPTH];
	logic [twq_pkg::TAG_BITS-1:0] tag_a [QUEUE_DEPTH];

	assign occ[QUEUE_DEPTH] = 1'b0;
	assign occ_prev = {occ[QUEUE_DEPTH-2:0], 1'b1};
	assign head_len = len_a[0];
	assign head_tag = tag_a[0];

	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		localparam int NXT = (i == QUEUE_DEPTH - 1) ? i : i + 1;
		assign occ[i] = COUNT_BITS'(i) < count;
		twq_cell #(
			.LENGTH_BITS(LENGTH_BITS)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.occ_self (occ[i]),
			.occ_prev (occ_prev[i]),
			.occ_next (occ[i+1]),
			.next_len (len_a[NXT]),
			.next_tag (tag_a[NXT]),
			.head_len (len_a[0]),
			.head_tag (tag_a[0]),
			.in_len   (in_len),
			.in_tag   (in_tag),
			.len_q    (len_a[i]),
			.tag_q    (tag_a[i])
		);
	end
endmodule
`default_nettype wire

// ----- rtl/core/tagged_write_queue_byte_budget.sv -----
// Enqueue, close, take-next, completion: result registered in the cycle after accept.
// Throughput: those requests go one per cycle while the response side keeps taking.
// Drop by tag: every queued entry passes through the head cell, one entry a cycle.
// Reset (arst_n low): empty queue, zero byte counts, flags clear, budget 1048576.
// Descriptor cells are not cleared; no sweep after reset.
`timescale 1ns / 1ps
`default_nettype none
`include "tagged_write_queue_byte_budget_assert.svh"
module tagged_write_queue_byte_budget #(
	parameter int QUEUE_DEPTH = 64,
	parameter int LENGTH_BITS = 16
) (
	input  wire                                clk,
	input  wire                                arst_n,
	twq_req_if.sink                            req,
	twq_rsp_if.source                          rsp,
	input  wire                                cfg_we,
	input  wire [twq_pkg::BUDGET_BITS-1:0]     cfg_wdata
);
	localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
	localparam int BACKLOG_BITS =
		((LENGTH_BITS > twq_pkg::BUDGET_BITS) ? LENGTH_BITS : twq_pkg::BUDGET_BITS) + 1;
	localparam logic [COUNT_BITS-1:0] DEPTH_C = COUNT_BITS'(QUEUE_DEPTH);

	typedef enum logic {ST_IDLE, ST_DROP} state_t;

	// control and status
	state_t                        state_q, state_d;
	logic [COUNT_BITS-1:0]         count_q, count_d;
	logic [BACKLOG_BITS-1:0]       backlog_q, backlog_d;
	logic [LENGTH_BITS-1:0]        inflight_q, inflight_d;
	logic                          failed_q, failed_d;
	logic                          closed_q, closed_d;
	logic [twq_pkg::BUDGET_BITS-1:0] budget_q;

	// drop sweep
	logic [twq_pkg::TAG_BITS-1:0]  drop_tag_q, drop_tag_d;
	logic [COUNT_BITS-1:0]         remain_q, remain_d;
	logic [COUNT_BITS-1:0]         dropped_q, dropped_d;

	// response register
	logic                          out_valid_q;
	logic                          out_accepted_q;
	logic [COUNT_BITS-1:0]         out_dropped_q;
	logic                          out_sent_valid_q;
	logic [LENGTH_BITS-1:0]        out_sent_len_q;
	logic [twq_pkg::TAG_BITS-1:0]  out_sent_tag_q;

	logic                          produce;
	logic                          res_accepted;
	logic [COUNT_BITS-1:0]         res_dropped;
	logic                          res_sent_valid;
	logic [LENGTH_BITS-1:0]        res_sent_len;
	logic [twq_pkg::TAG_BITS-1:0]  res_sent_tag;

	twq_pkg::chain_ctrl_t          ctrl;
	twq_pkg::req_type_t            req_code;
	logic                          in_ready;
	logic                          accept;
	logic [BACKLOG_BITS:0]         enq_sum;
	logic                          enq_ok;
	logic                          head_match;
	logic [LENGTH_BITS-1:0]        head_len;
	logic [twq_pkg::TAG_BITS-1:0]  head_tag;

	// A request enters only when idle and the response slot is free or draining,
	// so the live status registers always match the pending response.
	assign in_ready = (state_q == ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept   = req.valid && in_ready;
	assign req_code = twq_pkg::req_type_t'(req.req_type);

	// budget applies only once something is already queued
	assign enq_sum = {1'b0, backlog_q} + (BACKLOG_BITS + 1)'(req.frame_length);
	assign enq_ok  = !closed_q && !failed_q && (count_q < DEPTH_C) &&
		((count_q == '0) || (enq_sum <= (BACKLOG_BITS + 1)'(budget_q)));

	assign head_match = (head_tag == drop_tag_q);

	twq_chain #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.LENGTH_BITS(LENGTH_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_chain (
		.clk      (clk),
		.count    (count_q),
		.ctrl     (ctrl),
		.in_len   (req.frame_length),
		.in_tag   (req.tag),
		.head_len (head_len),
		.head_tag (head_tag)
	);

	always_comb begin
		ctrl           = '0;
		state_d        = state_q;
		count_d        = count_q;
		backlog_d      = backlog_q;
		inflight_d     = inflight_q;
		failed_d       = failed_q;
		closed_d       = closed_q;
		drop_tag_d     = drop_tag_q;
		remain_d       = remain_q;
		dropped_d      = dropped_q;
		produce        = 1'b0;
		res_accepted   = 1'b0;
		res_dropped    = '0;
		res_sent_valid = 1'b0;
		res_sent_len   = '0;
		res_sent_tag   = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_code)
						twq_pkg::REQ_ENQUEUE: begin
							produce = 1'b1;
							if (enq_ok) begin
								ctrl.load    = 1'b1;
								count_d      = count_q + COUNT_BITS'(1);
								backlog_d    = backlog_q + BACKLOG_BITS'(req.frame_length);
								res_accepted = 1'b1;
							end
						end
						twq_pkg::REQ_DROP: begin
							// untagged or empty: nothing to sweep
							if ((req.tag != '0) && (count_q != '0)) begin
								state_d    = ST_DROP;
								remain_d   = count_q;
								dropped_d  = '0;
								drop_tag_d = req.tag;
							end else begin
								produce = 1'b1;
							end
						end
						twq_pkg::REQ_CLOSE: begin
							produce    = 1'b1;
							closed_d   = 1'b1;
							count_d    = '0;
							backlog_d  = '0;
							inflight_d = '0;
						end
						twq_pkg::REQ_TAKE: begin
							produce = 1'b1;
							if ((count_q != '0) && !failed_q && !closed_q) begin
								ctrl.shift     = 1'b1;
								res_sent_valid = 1'b1;
								res_sent_len   = head_len;
								res_sent_tag   = head_tag;
								count_d        = count_q - COUNT_BITS'(1);
								backlog_d      = backlog_q - BACKLOG_BITS'(head_len);
								inflight_d     = head_len;
							end
						end
						twq_pkg::REQ_DONE: begin
							produce    = 1'b1;
							inflight_d = '0;
							if (req.write_failed) begin
								failed_d  = 1'b1;
								count_d   = '0;
								backlog_d = '0;
							end
						end
						default: begin
							produce = 1'b1;
						end
					endcase
				end
			end
			ST_DROP: begin
				// head leaves each cycle; survivors re-enter behind the last live cell
				ctrl.shift = 1'b1;
				ctrl.keep  = !head_match;
				remain_d   = remain_q - COUNT_BITS'(1);
				if (head_match) begin
					count_d   = count_q - COUNT_BITS'(1);
					backlog_d = backlog_q - BACKLOG_BITS'(head_len);
					dropped_d = dropped_q + COUNT_BITS'(1);
				end
				if (remain_q == COUNT_BITS'(1)) begin
					produce     = 1'b1;
					state_d     = ST_IDLE;
					res_dropped = dropped_d;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= ST_IDLE;
			count_q          <= '0;
			backlog_q        <= '0;
			inflight_q       <= '0;
			failed_q         <= 1'b0;
			closed_q         <= 1'b0;
			budget_q         <= twq_pkg::BUDGET_RESET;
			drop_tag_q       <= '0;
			remain_q         <= '0;
			dropped_q        <= '0;
			out_valid_q      <= 1'b0;
			out_accepted_q   <= 1'b0;
			out_dropped_q    <= '0;
			out_sent_valid_q <= 1'b0;
			out_sent_len_q   <= '0;
			out_sent_tag_q   <= '0;
		end else begin
			state_q    <= state_d;
			count_q    <= count_d;
			backlog_q  <= backlog_d;
			inflight_q <= inflight_d;
			failed_q   <= failed_d;
			closed_q   <= closed_d;
			drop_tag_q <= drop_tag_d;
			remain_q   <= remain_d;
			dropped_q  <= dropped_d;
			if (cfg_we) begin
				budget_q <= cfg_wdata;
			end
			if (produce) begin
				out_valid_q      <= 1'b1;
				out_accepted_q   <= res_accepted;
				out_dropped_q    <= res_dropped;
				out_sent_valid_q <= res_sent_valid;
				out_sent_len_q   <= res_sent_len;
				out_sent_tag_q   <= res_sent_tag;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign req.ready           = in_ready;
	assign rsp.valid           = out_valid_q;
	assign rsp.accepted        = out_accepted_q;
	assign rsp.dropped_count   = out_dropped_q;
	assign rsp.sent_valid      = out_sent_valid_q;
	assign rsp.sent_length     = out_sent_len_q;
	assign rsp.sent_tag        = out_sent_tag_q;
	// status: live registers equal the status after the pending request
	assign rsp.backlog_bytes   = backlog_q;
	assign rsp.in_flight_bytes = inflight_q;
	assign rsp.queued_count    = count_q;
	assign rsp.failed          = failed_q;
	assign rsp.closed          = closed_q;

	`TWQ_ASSERT(a_count_bound, clk, arst_n, count_q <= DEPTH_C, "entry count beyond depth")
	`TWQ_ASSERT(a_empty_no_bytes, clk, arst_n, (count_q != '0) || (backlog_q == '0),
		"backlog bytes with an empty queue")
	`TWQ_ASSERT(a_closed_clear, clk, arst_n,
		!closed_q || ((count_q == '0) && (inflight_q == '0)), "closed queue not empty")
	`TWQ_ASSERT(a_drop_blocks, clk, arst_n, (state_q == ST_DROP) |-> !req.ready,
		"request taken during drop sweep")
	`TWQ_ASSERT_NEXT(a_drop_no_rsp, clk, arst_n,
		(state_q == ST_IDLE) && accept && (req_code == twq_pkg::REQ_DROP) &&
		(req.tag != '0) && (count_q != '0) && !rsp.ready,
		!out_valid_q, "response pending while drop sweep starts")
endmodule
`default_nettype wire
